>>> rtl/core/circle_polyline_generator_unit_defines.svh
// Assertion macros shared by the circle polyline generator RTL.
`ifndef CIRCLE_POLYLINE_GENERATOR_UNIT_DEFINES_SVH
`define CIRCLE_POLYLINE_GENERATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/cpg_pkg.sv
`default_nettype none

package cpg_pkg;

  // Segment count width and the widths that follow from it.
  localparam int STEP_COUNT_BITS = 14;
  localparam int N2_W  = 2 * STEP_COUNT_BITS;
  localparam int N3X_W = STEP_COUNT_BITS + 2;
  localparam int DSR_W = 3 * STEP_COUNT_BITS + 2;

  // Shared multiplier operand widths.
  localparam int MUL_A_W = ((N2_W > 31) ? N2_W : 31) + 1;
  localparam int MUL_B_W = ((N3X_W + 1 > 20) ? N3X_W + 1 : 20);
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Fixed-point format widths.
  localparam int STEP_W  = 18;
  localparam int UNIT_W  = 20;
  localparam int ACC_W   = 40;
  localparam int OFF_W   = 36;
  localparam int FRAC_W  = 16;

  // Divider dividend width: wide enough for the cube of pi in 16.16, which has 48 fraction bits.
  localparam int DIV_W = 53;
  // Divider step counter width.
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Fixed-point constants, worked out at elaboration.
  localparam longint unsigned FIX_ONE = 64'd65536;
  localparam longint unsigned FIX_PI  = 64'd205887;
  localparam longint unsigned PI_TWO  = FIX_PI * 64'd2;
  localparam longint unsigned PI_SQ   = FIX_PI * FIX_PI;
  localparam longint unsigned PI_CUBE = PI_SQ * FIX_PI;

  // Segment count selection.
  localparam int SMALL_RADIUS_LIMIT = 90;
  localparam int LARGE_RADIUS_BASE  = 92;
  localparam int SMALL_RADIUS_BASE  = 16;
  localparam int COS_SHIFT          = 15;
  localparam int SIN_SHIFT          = 30;

  // Operation codes.
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef struct packed {
    logic              operation;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [30:0]       radius;
  } cpg_item_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic              last_point;
  } cpg_point_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_resp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_NCOUNT,
    ST_NSQ,
    ST_NCUBE,
    ST_DIV_COS,
    ST_WAIT_COS,
    ST_DIV_SIN,
    ST_WAIT_SIN,
    ST_DIV_CUBE,
    ST_WAIT_CUBE,
    ST_ROT_XC,
    ST_ROT_XS,
    ST_ROT_YS,
    ST_ROT_YC,
    ST_ROT_NY,
    ST_VTX_X,
    ST_VTX_Y,
    ST_HEAD,
    ST_EMIT
  } cpg_state_t;

endpackage

`default_nettype wire

>>> rtl/core/cpg_div.sv
`default_nettype none

module cpg_div import cpg_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire div_req_t  req,
  output div_resp_t      resp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DSR_W-1:0]     rem;
  logic [DIV_W-1:0]     quo;
  logic [DSR_W-1:0]     dsr;

  logic [DSR_W:0]   shifted;
  logic [DSR_W+1:0] trial;
  logic             fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem, quo[DIV_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dsr};
    fits    = !trial[DSR_W+1];
  end

  // Iteration control: one quotient bit per cycle, done pulses once at the end.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= fits ? trial[DSR_W-1:0] : shifted[DSR_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign resp.busy     = busy;
  assign resp.done     = done;
  assign resp.quotient = quo;

endmodule

`default_nettype wire

>>> rtl/core/circle_polyline_generator_unit.sv
`default_nettype none
// Circle flattening unit: a start transaction (operation 0) takes the centre and radius in
// 16.16 fixed point and returns the head point (cx + r, cy) after three 53-step divisions
// on the shared restoring divider that derive the rotation factors. Each advance transaction
// (operation 1) returns the next vertex after six passes through the shared 32 x 20
// multiplier (four for the rotation, two for the scaling). Once all segments are out, one
// more advance returns the head point with last_point set; an advance while no circle is
// active returns nothing. One transaction is worked on at a time, and a new one is taken
// while the previous result still waits in the output register.

module circle_polyline_generator_unit import cpg_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_ready,
  input  wire cpg_item_t  item,
  output logic            point_valid,
  input  wire logic       point_ready,
  output cpg_point_t      point
);

  `include "circle_polyline_generator_unit_defines.svh"

  cpg_state_t state;
  cpg_state_t state_next;

  // Control state.
  logic                       active;
  logic [STEP_COUNT_BITS-1:0] steps_left;
  logic                       closing;

  // Circle parameters and derived factors.
  logic signed [31:0]         saved_center_x;
  logic signed [31:0]         saved_center_y;
  logic [30:0]                saved_radius;
  logic [STEP_COUNT_BITS-1:0] seg_count;
  logic [N2_W-1:0]            seg_sq;
  logic [DSR_W-1:0]           seg_cube3;
  logic [STEP_W-1:0]          cos_step;
  logic [STEP_W-1:0]          sin_step;
  logic signed [UNIT_W-1:0]   unit_x;
  logic signed [UNIT_W-1:0]   unit_y;
  logic signed [UNIT_W-1:0]   next_x;
  logic signed [ACC_W-1:0]    acc;
  logic signed [31:0]         vtx_x;
  logic signed [31:0]         vtx_y;

  // Shared multiplier.
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod;

  // Divider link.
  div_req_t                   div_req;
  div_resp_t                  div_resp;

  // Combinational helpers.
  logic [14:0]                radius_int;
  logic                       radius_small;
  logic [15:0]                div3_arg;
  logic [32:0]                div3_prod;
  logic [15:0]                seg_raw;
  logic [N3X_W-1:0]           seg_x3;
  logic signed [ACC_W-1:0]    rot_diff;
  logic signed [ACC_W-1:0]    rot_sum;
  logic signed [OFF_W-1:0]    vtx_off;
  logic signed [36:0]         sum_x;
  logic signed [36:0]         dif_y;
  logic                       accept;
  logic                       emit_free;

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if ((v[36:31] == 6'b000000) || (v[36:31] == 6'b111111)) begin
      r = v[31:0];
    end else if (v[36]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  cpg_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .resp (div_resp)
  );

  assign accept    = item_valid && item_ready;
  assign emit_free = !point_valid || point_ready;

  // Segment count from the integer radius; division by three is a reciprocal multiply.
  always_comb begin
    radius_int   = saved_radius[30:16];
    radius_small = (radius_int < 15'(SMALL_RADIUS_LIMIT));
    div3_arg     = radius_small ? 16'({radius_int, 2'b00}) : 16'(radius_int);
    div3_prod    = 33'(div3_arg) * 33'd43691;
    seg_raw      = div3_prod[32:17] +
                   (radius_small ? 16'(SMALL_RADIUS_BASE) : 16'(LARGE_RADIUS_BASE));
    seg_x3       = N3X_W'({seg_count, 1'b0}) + N3X_W'(seg_count);
  end

  // Rotation accumulate and vertex offset arithmetic.
  always_comb begin
    rot_diff = acc - $signed(prod[ACC_W-1:0]);
    rot_sum  = acc + $signed(prod[ACC_W-1:0]);
    if (state == ST_HEAD) begin
      vtx_off = OFF_W'({1'b0, saved_radius});
    end else begin
      vtx_off = prod[OFF_W+FRAC_W-1:FRAC_W];
    end
    sum_x = 37'(saved_center_x) + 37'(vtx_off);
    dif_y = 37'(saved_center_y) - 37'(vtx_off);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          if (item.operation == OP_START) begin
            state_next = ST_NCOUNT;
          end else if (active) begin
            state_next = (steps_left == '0) ? ST_HEAD : ST_ROT_XC;
          end
        end
      end
      ST_NCOUNT:    state_next = ST_NSQ;
      ST_NSQ:       state_next = ST_NCUBE;
      ST_NCUBE:     state_next = ST_DIV_COS;
      ST_DIV_COS:   state_next = ST_WAIT_COS;
      ST_WAIT_COS:  state_next = div_resp.done ? ST_DIV_SIN : ST_WAIT_COS;
      ST_DIV_SIN:   state_next = ST_WAIT_SIN;
      ST_WAIT_SIN:  state_next = div_resp.done ? ST_DIV_CUBE : ST_WAIT_SIN;
      ST_DIV_CUBE:  state_next = ST_WAIT_CUBE;
      ST_WAIT_CUBE: state_next = div_resp.done ? ST_HEAD : ST_WAIT_CUBE;
      ST_ROT_XC:    state_next = ST_ROT_XS;
      ST_ROT_XS:    state_next = ST_ROT_YS;
      ST_ROT_YS:    state_next = ST_ROT_YC;
      ST_ROT_YC:    state_next = ST_ROT_NY;
      ST_ROT_NY:    state_next = ST_VTX_X;
      ST_VTX_X:     state_next = ST_VTX_Y;
      ST_VTX_Y:     state_next = ST_EMIT;
      ST_HEAD:      state_next = ST_EMIT;
      ST_EMIT:      state_next = emit_free ? ST_IDLE : ST_EMIT;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake, multiplier operands and divider requests.
  always_comb begin
    item_ready       = (state == ST_IDLE);
    mul_a            = '0;
    mul_b            = '0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state)
      ST_NSQ: begin
        mul_a = MUL_A_W'(seg_count);
        mul_b = MUL_B_W'(seg_count);
      end
      ST_NCUBE: begin
        mul_a = MUL_A_W'(prod[N2_W-1:0]);
        mul_b = MUL_B_W'(seg_x3);
      end
      ST_DIV_COS: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(PI_SQ);
        div_req.divisor  = DSR_W'(seg_sq);
      end
      ST_DIV_SIN: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(PI_TWO);
        div_req.divisor  = DSR_W'(seg_count);
      end
      ST_DIV_CUBE: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(PI_CUBE);
        div_req.divisor  = seg_cube3;
      end
      ST_ROT_XC: begin
        mul_a = MUL_A_W'(unit_x);
        mul_b = MUL_B_W'(cos_step);
      end
      ST_ROT_XS: begin
        mul_a = MUL_A_W'(unit_y);
        mul_b = MUL_B_W'(sin_step);
      end
      ST_ROT_YS: begin
        mul_a = MUL_A_W'(unit_x);
        mul_b = MUL_B_W'(sin_step);
      end
      ST_ROT_YC: begin
        mul_a = MUL_A_W'(unit_y);
        mul_b = MUL_B_W'(cos_step);
      end
      ST_ROT_NY: begin
        mul_a = MUL_A_W'({1'b0, saved_radius});
        mul_b = MUL_B_W'(next_x);
      end
      ST_VTX_X: begin
        mul_a = MUL_A_W'({1'b0, saved_radius});
        mul_b = MUL_B_W'(unit_y);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      active      <= 1'b0;
      steps_left  <= '0;
      closing     <= 1'b0;
      point_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        // Only the advance that follows the last rotation closes the polyline.
        closing <= (item.operation == OP_ADVANCE) && (steps_left == '0);
        if ((item.operation == OP_ADVANCE) && active && (steps_left == '0)) begin
          active <= 1'b0;
        end
      end
      if ((state == ST_WAIT_CUBE) && div_resp.done) begin
        active     <= 1'b1;
        steps_left <= seg_count;
      end
      if (state == ST_ROT_NY) begin
        steps_left <= steps_left - 1'b1;
      end
      if ((state == ST_EMIT) && emit_free) begin
        point_valid <= 1'b1;
      end else if (point_ready) begin
        point_valid <= 1'b0;
      end
    end
  end

  // Shared multiplier with its product register.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Datapath registers, loaded by sequencer step.
  always_ff @(posedge clk) begin
    if (accept && (item.operation == OP_START)) begin
      saved_center_x <= item.center_x;
      saved_center_y <= item.center_y;
      saved_radius   <= item.radius;
    end
    case (state)
      ST_NCOUNT: begin
        if (seg_raw > 16'((1 << STEP_COUNT_BITS) - 1)) begin
          seg_count <= '1;
        end else begin
          seg_count <= seg_raw[STEP_COUNT_BITS-1:0];
        end
      end
      ST_NCUBE: begin
        seg_sq <= prod[N2_W-1:0];
      end
      ST_DIV_COS: begin
        seg_cube3 <= prod[DSR_W-1:0];
      end
      ST_WAIT_COS: begin
        if (div_resp.done) begin
          cos_step <= STEP_W'(FIX_ONE) - STEP_W'(div_resp.quotient >> COS_SHIFT);
        end
      end
      ST_WAIT_SIN: begin
        if (div_resp.done) begin
          sin_step <= div_resp.quotient[STEP_W-1:0];
        end
      end
      ST_WAIT_CUBE: begin
        if (div_resp.done) begin
          sin_step <= sin_step - STEP_W'(div_resp.quotient >> SIN_SHIFT);
          unit_x   <= UNIT_W'(FIX_ONE);
          unit_y   <= '0;
        end
      end
      ST_ROT_XS: begin
        acc <= prod[ACC_W-1:0];
      end
      ST_ROT_YS: begin
        next_x <= rot_diff[UNIT_W+FRAC_W-1:FRAC_W];
      end
      ST_ROT_YC: begin
        acc <= prod[ACC_W-1:0];
      end
      ST_ROT_NY: begin
        unit_x <= next_x;
        unit_y <= rot_sum[UNIT_W+FRAC_W-1:FRAC_W];
      end
      ST_VTX_X: begin
        vtx_x <= sat32(sum_x);
      end
      ST_VTX_Y: begin
        vtx_y <= sat32(dif_y);
      end
      ST_HEAD: begin
        vtx_x <= sat32(sum_x);
        vtx_y <= saved_center_y;
      end
      ST_EMIT: begin
        if (emit_free) begin
          point.point_x    <= vtx_x;
          point.point_y    <= vtx_y;
          point.last_point <= closing;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  // The divider must be quiet whenever a new transaction can be taken.
  `CPG_ASSERT_SAME(a_div_quiet_idle, clk, rst, state == ST_IDLE, !div_resp.busy,
                   "divider busy while idle")

  // A finished division is only ever seen by a state that waits for it.
  `CPG_ASSERT_SAME(a_div_done_waited, clk, rst, div_resp.done,
                   (state == ST_WAIT_COS) || (state == ST_WAIT_SIN) ||
                   (state == ST_WAIT_CUBE), "division result not consumed")

  // A rotation is never started with no segments left.
  `CPG_ASSERT_SAME(a_rot_has_steps, clk, rst, state == ST_ROT_XC, steps_left != '0,
                   "rotation with no segments left")

  // Every rotation consumes exactly one segment.
  `CPG_ASSERT_NEXT(a_rot_counts_down, clk, rst, state == ST_ROT_NY,
                   (steps_left + 1'b1) == $past(steps_left), "segment count not decremented")

  // A fresh circle always has at least the minimum segment count and is active.
  `CPG_ASSERT_SAME(a_head_segments, clk, rst, (state == ST_HEAD) && !closing,
                   active && (steps_left >= STEP_COUNT_BITS'(SMALL_RADIUS_BASE)),
                   "start head point without a valid segment count")

endmodule

`default_nettype wire
